@@ rtl/core/hbcc_pkg.sv @@
// Package for the hash bucket collision counter.
// Holds widths, register indexes, FSM state type and the FNV prime multiply.
// No dependencies.
package hbcc_pkg;

  localparam int KEY_W        = 32;
  localparam int BUCKET_BITS  = 20;
  localparam int CNT_W        = 32;
  localparam int MASK_W       = 5;
  localparam int BYTE_W       = 8;
  localparam int KEY_BYTES    = KEY_W / BYTE_W;
  localparam int BYTE_CNT_W   = $clog2(KEY_BYTES);
  localparam int ROW_W        = 32;
  localparam int ROW_SEL_W    = $clog2(ROW_W);
  localparam int ROW_ADDR_W   = BUCKET_BITS - ROW_SEL_W;
  localparam int OUT_DATA_W   = ((BUCKET_BITS + 1 + CNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - (BUCKET_BITS + 1 + CNT_W);

  localparam logic [KEY_W-1:0] FNV32_BASIS = 32'd2166136261;
  localparam logic [MASK_W-1:0] MASK_MAX   = MASK_W'(BUCKET_BITS);

  // Configuration register indexes
  localparam logic REG_HASH_MODE = 1'b0;
  localparam logic REG_MASK_BITS = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_FOLD,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Multiply by the FNV 32-bit prime 2^24 + 0x193 as a sum of shifts.
  function automatic logic [KEY_W-1:0] fnv_mul(input logic [KEY_W-1:0] h);
    fnv_mul = (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
  endfunction

endpackage

@@ rtl/core/hash_bucket_collision_counter.sv @@
// Top level of the hash bucket collision counter.
// Byte-serial FNV-1a / mask hash, occupancy bit memory and collision count.
// Depends on hbcc_pkg.
//
// Usage:
//   in_*  : one 32-bit key per beat (in_tdata).
//   out_* : one result per key: out_tdata holds bucket_index [19:0],
//           collided [20], collision_total [52:21], zero pad [55:53].
//   cfg_* : write port; index 0 is hash_mode, index 1 is mask_bits.
//           Write only while the block is idle.
// Timing: the key is hashed one byte per cycle in ST_HASH, then ST_FOLD
//   registers the folded or masked bucket, ST_READ registers the occupancy
//   row and ST_UPDATE writes the row back and loads the output register.
//   Only one key is in flight: a new key is taken in ST_IDLE, after the
//   previous key's update.
// Reset: a clearing pass writes the 32768 occupancy rows, one per cycle;
//   in_tready stays low until the pass ends. Config writes are taken.
// Stall: a result waits in the output register; the next key is hashed
//   meanwhile and holds before its update until the result is taken.
module hash_bucket_collision_counter (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: key_value [31:0]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hbcc_pkg::KEY_W-1:0]      in_tdata,
  // out_tdata: bucket_index [19:0], collided [20], collision_total [52:21]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hbcc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [hbcc_pkg::MASK_W-1:0]     cfg_wdata
);

  localparam int ROWS = 1 << hbcc_pkg::ROW_ADDR_W;

  hbcc_pkg::state_t state_r, state_nxt;

  logic [hbcc_pkg::ROW_ADDR_W-1:0]  clr_row_r;
  logic [hbcc_pkg::BYTE_CNT_W-1:0]  byte_cnt_r;
  logic [hbcc_pkg::KEY_W-1:0]       key_r;
  logic [hbcc_pkg::KEY_W-1:0]       key_sh_r;
  logic [hbcc_pkg::KEY_W-1:0]       h_r;
  logic [hbcc_pkg::BUCKET_BITS-1:0] bucket_r;
  logic [hbcc_pkg::ROW_W-1:0]       rd_row_r;
  logic [hbcc_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             hash_mode_r;
  logic [hbcc_pkg::MASK_W-1:0]      mask_bits_r;
  logic                             out_valid_r;
  logic [hbcc_pkg::OUT_DATA_W-1:0]  out_data_r;

  logic [hbcc_pkg::ROW_W-1:0]       occ_mem [0:ROWS-1];

  logic                             in_fire;
  logic                             advance;
  logic                             mem_we;
  logic [hbcc_pkg::ROW_ADDR_W-1:0]  mem_waddr;
  logic [hbcc_pkg::ROW_W-1:0]       mem_wdata;
  logic [hbcc_pkg::ROW_W-1:0]       bit_sel;
  logic                             hit;
  logic [hbcc_pkg::MASK_W-1:0]      mask_n;
  logic [hbcc_pkg::BUCKET_BITS:0]   mask_wide;
  logic [hbcc_pkg::BUCKET_BITS-1:0] fold;
  logic [hbcc_pkg::BUCKET_BITS-1:0] bucket_nxt;
  logic [hbcc_pkg::KEY_W-1:0]       h_step;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hbcc_pkg::ST_CLEAR: begin
        if (clr_row_r == {hbcc_pkg::ROW_ADDR_W{1'b1}}) state_nxt = hbcc_pkg::ST_IDLE;
      end
      hbcc_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = hbcc_pkg::ST_HASH;
      end
      hbcc_pkg::ST_HASH: begin
        if (byte_cnt_r == {hbcc_pkg::BYTE_CNT_W{1'b1}}) state_nxt = hbcc_pkg::ST_FOLD;
      end
      hbcc_pkg::ST_FOLD:   state_nxt = hbcc_pkg::ST_READ;
      hbcc_pkg::ST_READ:   state_nxt = hbcc_pkg::ST_UPDATE;
      hbcc_pkg::ST_UPDATE: begin
        if (!out_valid_r || out_tready) state_nxt = hbcc_pkg::ST_IDLE;
      end
      default: state_nxt = hbcc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    advance   = 1'b0;
    mem_we    = 1'b0;
    unique case (state_r)
      hbcc_pkg::ST_CLEAR:  mem_we = 1'b1;
      hbcc_pkg::ST_IDLE:   in_tready = 1'b1;
      hbcc_pkg::ST_UPDATE: begin
        advance = !out_valid_r || out_tready;
        mem_we  = advance;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign in_fire = in_tvalid && in_tready;

  // ------------------------------------------------------------ hashing
  assign h_step = hbcc_pkg::fnv_mul(h_r ^ {{(hbcc_pkg::KEY_W-hbcc_pkg::BYTE_W){1'b0}},
                                            key_sh_r[hbcc_pkg::BYTE_W-1:0]});

  // Fold high 12 bits onto the low 20, then decrement with wrap.
  assign fold = ({{(2*hbcc_pkg::BUCKET_BITS-hbcc_pkg::KEY_W){1'b0}},
                  h_r[hbcc_pkg::KEY_W-1:hbcc_pkg::BUCKET_BITS]}
                 ^ h_r[hbcc_pkg::BUCKET_BITS-1:0]) - hbcc_pkg::BUCKET_BITS'(1);

  // Clamp mask width to 1..20.
  always_comb begin
    priority if (mask_bits_r == '0) mask_n = hbcc_pkg::MASK_W'(1);
    else if (mask_bits_r > hbcc_pkg::MASK_MAX) mask_n = hbcc_pkg::MASK_MAX;
    else mask_n = mask_bits_r;
  end

  assign mask_wide  = ~({(hbcc_pkg::BUCKET_BITS+1){1'b1}} << mask_n);
  assign bucket_nxt = hash_mode_r ? fold
                                  : (key_r[hbcc_pkg::BUCKET_BITS-1:0]
                                     & mask_wide[hbcc_pkg::BUCKET_BITS-1:0]);

  // ---------------------------------------------------- occupancy update
  assign bit_sel = hbcc_pkg::ROW_W'(1) << bucket_r[hbcc_pkg::ROW_SEL_W-1:0];
  assign hit     = rd_row_r[bucket_r[hbcc_pkg::ROW_SEL_W-1:0]];

  assign mem_waddr = (state_r == hbcc_pkg::ST_CLEAR) ? clr_row_r
                   : bucket_r[hbcc_pkg::BUCKET_BITS-1:hbcc_pkg::ROW_SEL_W];
  assign mem_wdata = (state_r == hbcc_pkg::ST_CLEAR) ? '0 : (rd_row_r | bit_sel);

  assign cnt_nxt = (hit && cnt_r != {hbcc_pkg::CNT_W{1'b1}})
                 ? cnt_r + hbcc_pkg::CNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_waddr] <= mem_wdata;
    end
    rd_row_r <= occ_mem[bucket_r[hbcc_pkg::BUCKET_BITS-1:hbcc_pkg::ROW_SEL_W]];
  end

  // ---------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hbcc_pkg::ST_CLEAR;
      clr_row_r   <= '0;
      byte_cnt_r  <= '0;
      cnt_r       <= '0;
      hash_mode_r <= 1'b1;
      mask_bits_r <= hbcc_pkg::MASK_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hbcc_pkg::ST_CLEAR) clr_row_r <= clr_row_r + hbcc_pkg::ROW_ADDR_W'(1);
      if (state_r == hbcc_pkg::ST_HASH) begin
        byte_cnt_r <= byte_cnt_r + hbcc_pkg::BYTE_CNT_W'(1);
      end else begin
        byte_cnt_r <= '0;
      end
      if (advance) cnt_r <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          hbcc_pkg::REG_HASH_MODE: hash_mode_r <= cfg_wdata[0];
          hbcc_pkg::REG_MASK_BITS: mask_bits_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r    <= in_tdata;
      key_sh_r <= in_tdata;
      h_r      <= hbcc_pkg::FNV32_BASIS;
    end else if (state_r == hbcc_pkg::ST_HASH) begin
      // advance one key byte per cycle
      key_sh_r <= key_sh_r >> hbcc_pkg::BYTE_W;
      h_r      <= h_step;
    end
    if (state_r == hbcc_pkg::ST_FOLD) bucket_r <= bucket_nxt;
    if (advance) out_data_r <= {{hbcc_pkg::OUT_PAD_W{1'b0}}, cnt_nxt, hit, bucket_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------- assertions
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hbcc_pkg::ST_CLEAR |-> !in_tready)
    else $error("key accepted during clearing pass");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && cnt_r != $past(cnt_r) |-> cnt_r == $past(cnt_r) + hbcc_pkg::CNT_W'(1))
    else $error("collision count moved by more than one");

  a_update_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && state_r == hbcc_pkg::ST_IDLE)
    else $error("update did not load the output register");

  a_hash_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == hbcc_pkg::ST_HASH && byte_cnt_r == '0)
    else $error("accepted key did not start hashing");

endmodule

@@ tb/hbcc_checker.sv @@
// Scoreboard for the hash bucket collision counter: watches the key, result and
// register ports, predicts bucket, collision flag and running total per key.
// Depends on hbcc_pkg.
`timescale 1ns / 1ps

module hbcc_checker import hbcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [KEY_W-1:0]      in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [MASK_W-1:0]     cfg_wdata,
  output int                    fail_count
);

  localparam logic [KEY_W-1:0] HASH_MULT = 32'd16777619;

  // Lowest field last, so the layout matches out_tdata from bit 0 up.
  typedef struct packed {
    logic [CNT_W-1:0]       total;
    logic                   collided;
    logic [BUCKET_BITS-1:0] bucket;
  } insert_result_t;

  insert_result_t  pending_inserts[$];
  bit              occupied[int unsigned];
  logic            fnv_mode;
  logic [MASK_W-1:0] mask_width;
  logic [CNT_W-1:0]  collisions;

  initial fail_count = 0;

  function automatic logic [BUCKET_BITS-1:0] bucket_of(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0]       h;
    logic [BUCKET_BITS-1:0] folded;
    int unsigned            width;
    logic [BUCKET_BITS:0]   keep;
    if (fnv_mode) begin
      h = FNV32_BASIS;
      for (int b = 0; b < KEY_BYTES; b++) begin
        h = (h ^ {24'h0, key[BYTE_W*b +: BYTE_W]}) * HASH_MULT;
      end
      folded = BUCKET_BITS'(h >> BUCKET_BITS) ^ h[BUCKET_BITS-1:0];
      return folded - 1'b1;
    end
    // Width zero keeps one bit; widths past the table keep the whole table.
    width = (mask_width == 0) ? 1 : ((mask_width > MASK_MAX) ? BUCKET_BITS : mask_width);
    keep = (21'd1 << width) - 21'd1;
    return key[BUCKET_BITS-1:0] & keep[BUCKET_BITS-1:0];
  endfunction

  always @(posedge clk) begin : track
    insert_result_t got;
    insert_result_t want;
    if (!rst_n) begin
      occupied.delete();
      pending_inserts.delete();
      fnv_mode   = 1'b1;
      mask_width = MASK_MAX;
      collisions = '0;
    end else begin
      // Compare first: a result never belongs to a key taken at the same edge.
      if (out_tvalid && out_tready) begin
        got = out_tdata[BUCKET_BITS+CNT_W:0];
        if (pending_inserts.size() == 0) begin
          $error("unexpected result beat: bucket_index %0h", got.bucket);
          fail_count++;
        end else begin
          want = pending_inserts.pop_front();
          if (got.bucket !== want.bucket) begin
            $error("bucket_index: expected %0h, actual %0h", want.bucket, got.bucket);
            fail_count++;
          end
          if (got.collided !== want.collided) begin
            $error("collided: expected %0d, actual %0d", want.collided, got.collided);
            fail_count++;
          end
          if (got.total !== want.total) begin
            $error("collision_total: expected %0d, actual %0d", want.total, got.total);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HASH_MODE: fnv_mode   = cfg_wdata[0];
          REG_MASK_BITS: mask_width = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want.bucket   = bucket_of(in_tdata);
        want.collided = occupied.exists(want.bucket);
        // Saturate; the flag is reported even once the total is pinned.
        if (want.collided && collisions != '1) collisions++;
        occupied[want.bucket] = 1'b1;
        want.total = collisions;
        pending_inserts.push_back(want);
      end
    end
  end

endmodule

@@ tb/hash_bucket_collision_counter_test.sv @@
// Top of the hash bucket collision counter testbench: clock, reset, key stimulus,
// register writes, receiver back-pressure and the verdict.
// Depends on hbcc_pkg, hash_bucket_collision_counter and hbcc_checker.
`timescale 1ns / 1ps

module hash_bucket_collision_counter_test;
  import hbcc_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 400;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [KEY_W-1:0]      in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic                  cfg_index  = REG_HASH_MODE;
  logic [MASK_W-1:0]     cfg_wdata  = '0;

  int  fail_count;
  int  keys_sent    = 0;
  int  results_seen = 0;
  int  cycle_count  = 0;
  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  logic long_hold    = 1'b0;
  int  hold_cycles   = 0;
  logic [KEY_W-1:0] recent_keys[$];

  hash_bucket_collision_counter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  hbcc_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) results_seen <= results_seen + 1;
  end

  // Receiver: random stalls, plus one long hold-off that lets the block back up.
  always @(posedge clk) begin
    if (long_hold && hold_cycles < HOLD_CYCLES) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
      if (!long_hold) hold_cycles <= 0;
    end
  end

  task automatic send_key(input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    keys_sent++;
  endtask

  // Hold the input and wait until every predicted result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (results_seen != keys_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [MASK_W-1:0] width);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_HASH_MODE;
    cfg_wdata <= {4'($urandom_range(15)), mode};
    @(posedge clk);
    cfg_index <= REG_MASK_BITS;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    logic [KEY_W-1:0] key;
    int               pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      // Mostly repeats and narrow keys so that buckets fill and collide.
      if (pick < 35 && recent_keys.size() > 0)
        key = recent_keys[$urandom_range(recent_keys.size() - 1)];
      else if (pick < 55)
        key = $urandom_range(4095);
      else
        key = $urandom;
      recent_keys.push_back(key);
      if (recent_keys.size() > 32) void'(recent_keys.pop_front());
      send_key(key);
    end
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0]       probe;
    logic [KEY_W-1:0]       h;
    logic [KEY_W-1:0]       fold_zero_key;
    logic [BUCKET_BITS-1:0] folded;
    bit                     found;
    found = 1'b0;
    fold_zero_key = '0;
    probe = '0;
    // Find a key whose FNV-1a fold is zero, so its bucket wraps to the top.
    while (!found && probe < 32'h0100_0000) begin
      h = FNV32_BASIS;
      for (int b = 0; b < KEY_BYTES; b++) begin
        h = (h ^ {24'h0, probe[BYTE_W*b +: BYTE_W]}) * 32'd16777619;
      end
      folded = BUCKET_BITS'(h >> BUCKET_BITS) ^ h[BUCKET_BITS-1:0];
      if (folded == '0) begin
        found = 1'b1;
        fold_zero_key = probe;
      end
      probe++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings (FNV-1a), key extremes and repeated buckets.
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    send_key(fold_zero_key);
    send_key(fold_zero_key);
    send_key(32'h8000_0001);
    send_key(32'h0000_00FF);
    // Mask of width zero behaves as one bit.
    set_config(1'b0, 5'd0);
    send_key(32'h0000_0000);
    send_key(32'h0000_0001);
    send_key(32'h0000_0002);
    send_key(32'hFFFF_FFFF);
    // Width past the table size clamps to the full table.
    set_config(1'b0, 5'd31);
    send_key(32'hFFFF_FFFF);
    send_key(32'h000F_FFFF);
    send_key(32'h0010_0000);
    set_config(1'b0, 5'd21);
    send_key(32'h7FFF_FFFF);
    set_config(1'b0, 5'd1);
    send_key(32'h0000_0003);
    send_key(32'hABCD_0004);
    set_config(1'b1, 5'd1);
    send_key(32'h7FFF_FFFF);
    send_key(32'h0000_0000);

    // Random phases over several settings and idling patterns.
    set_config(1'b1, 5'd20);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(300);

    set_config(1'b0, 5'd12);
    send_idle_pct = 55;
    stall_pct     = 0;
    run_random(350);

    set_config(1'b0, 5'd20);
    send_idle_pct = 0;
    stall_pct     = 55;
    long_hold <= 1'b1;
    run_random(350);
    long_hold <= 1'b0;

    set_config(1'b1, 5'd5);
    send_idle_pct = 18;
    stall_pct     = 18;
    run_random(350);

    set_config(1'b0, 5'd8);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(300);

    set_config(1'b0, 5'd1);
    send_idle_pct = 55;
    stall_pct     = 55;
    run_random(150);

    set_config(1'b1, 5'd16);
    send_idle_pct = 18;
    stall_pct     = 18;
    run_random(200);

    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
